// ===== rtl/satr_pkg.sv =====
package satr_pkg;

  localparam int COLUMNS   = 40;
  localparam int TEXT_ROWS = 28;

  // Decoupling queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int GLYPH_DEPTH = 2048;
  localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);

  localparam logic [5:0] LAST_COLUMN = 6'(COLUMNS - 1);
  localparam logic [4:0] LAST_ROW    = 5'(TEXT_ROWS - 1);
  localparam logic [2:0] INK_RESET   = 3'd7;
  localparam logic [2:0] ALL_ONES    = 3'd7;

  typedef enum logic [1:0] {
    OP_GLYPH_WRITE = 2'd0,
    OP_LINE_START  = 2'd1,
    OP_CELL        = 2'd2,
    OP_UNUSED      = 2'd3
  } satr_op_t;

  // Attribute group held in bits 4..3 of an attribute byte.
  typedef enum logic [1:0] {
    ATTR_INK   = 2'd0,
    ATTR_TEXT  = 2'd1,
    ATTR_PAPER = 2'd2,
    ATTR_MODE  = 2'd3
  } satr_attr_t;

  // One request handed from the front to the back.
  typedef struct packed {
    logic                is_write;
    logic                solid;
    logic                last;
    logic [GLYPH_AW-1:0] addr;
    logic [5:0]          wdata;
    logic [2:0]          fg;
    logic [2:0]          bg;
  } satr_entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic            full;
    logic            empty;
    logic [Q_CW-1:0] count;
  } satr_q_stat_t;

endpackage

// ===== rtl/satr_front.sv =====
module satr_front
  import satr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [7:0]           data_byte,
  input  logic [10:0]          glyph_index,
  input  logic [7:0]           line_number,
  input  logic                 blink_phase,
  input  satr_q_stat_t         q_stat,
  output logic                 push,
  output satr_entry_t          push_entry
);

  logic [2:0] ink_colour, ink_colour_next;
  logic [2:0] paper_colour, paper_colour_next;
  logic [2:0] text_attributes, text_attributes_next;
  logic [4:0] char_row, char_row_next;
  logic [2:0] glyph_line, glyph_line_next;
  logic       blink_latch, blink_latch_next;
  logic [5:0] column_count, column_count_next;

  logic       accept;
  logic       is_attr;
  logic       inv;
  logic [2:0] erow;
  logic [4:0] row_in;
  logic       at_last;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign is_attr  = (data_byte[6:5] == 2'b00);
  assign at_last  = (column_count == LAST_COLUMN);
  assign row_in   = line_number[7:3];

  always_comb begin
    ink_colour_next      = ink_colour;
    paper_colour_next    = paper_colour;
    text_attributes_next = text_attributes;
    char_row_next        = char_row;
    glyph_line_next      = glyph_line;
    blink_latch_next     = blink_latch;
    column_count_next    = column_count;
    push                 = 1'b0;
    inv                  = 1'b0;
    erow                 = glyph_line;

    push_entry.is_write = 1'b0;
    push_entry.solid    = 1'b0;
    push_entry.last     = at_last;
    push_entry.addr     = glyph_index;
    push_entry.wdata    = data_byte[5:0];
    push_entry.fg       = ink_colour;
    push_entry.bg       = paper_colour;

    case (opcode)
      OP_GLYPH_WRITE: begin
        push                = accept;
        push_entry.is_write = 1'b1;
      end
      OP_LINE_START: begin
        if (accept) begin
          char_row_next        = (row_in > LAST_ROW) ? LAST_ROW : row_in;
          glyph_line_next      = line_number[2:0];
          blink_latch_next     = blink_phase;
          ink_colour_next      = INK_RESET;
          paper_colour_next    = '0;
          text_attributes_next = '0;
          column_count_next    = '0;
        end
      end
      OP_CELL: begin
        push = accept;
        if (accept) begin
          column_count_next = at_last ? 6'd0 : column_count + 6'd1;
        end
        if (is_attr) begin
          case (data_byte[4:3])
            ATTR_INK:   ink_colour_next      = data_byte[2:0];
            ATTR_TEXT:  text_attributes_next = data_byte[2:0];
            ATTR_PAPER: paper_colour_next    = data_byte[2:0];
            ATTR_MODE:  ;
            default:    ;
          endcase
          // The attribute cell shows the paper colour as it stands after the update, inverted when bit 7 is set.
          push_entry.solid = 1'b1;
          push_entry.bg    = data_byte[7] ? (paper_colour_next ^ ALL_ONES)
                                          : paper_colour_next;
          if (!accept) begin
            ink_colour_next      = ink_colour;
            text_attributes_next = text_attributes;
            paper_colour_next    = paper_colour;
          end
        end else begin
          inv  = data_byte[7] ^ (text_attributes[2] & blink_latch);
          erow = text_attributes[1] ? {char_row[0], glyph_line[2:1]} : glyph_line;
          push_entry.addr = {text_attributes[0], data_byte[6:0], erow};
          push_entry.fg   = inv ? (ink_colour ^ ALL_ONES) : ink_colour;
          push_entry.bg   = inv ? (paper_colour ^ ALL_ONES) : paper_colour;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ink_colour      <= INK_RESET;
      paper_colour    <= '0;
      text_attributes <= '0;
      char_row        <= '0;
      glyph_line      <= '0;
      blink_latch     <= 1'b0;
      column_count    <= '0;
    end else begin
      ink_colour      <= ink_colour_next;
      paper_colour    <= paper_colour_next;
      text_attributes <= text_attributes_next;
      char_row        <= char_row_next;
      glyph_line      <= glyph_line_next;
      blink_latch     <= blink_latch_next;
      column_count    <= column_count_next;
    end
  end

endmodule

// ===== rtl/satr_queue.sv =====
module satr_queue
  import satr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  satr_entry_t  push_entry,
  input  logic         pop,
  output satr_entry_t  head,
  output satr_q_stat_t q_stat
);

  satr_entry_t     slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.count = count;
  assign q_stat.full  = (count == Q_CW'(Q_DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/satr_back.sv =====
module satr_back
  import satr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  satr_entry_t  head,
  input  satr_q_stat_t q_stat,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   pixel_0,
  output logic [2:0]   pixel_1,
  output logic [2:0]   pixel_2,
  output logic [2:0]   pixel_3,
  output logic [2:0]   pixel_4,
  output logic [2:0]   pixel_5,
  output logic         last_in_line
);

  logic [5:0] glyph_store [GLYPH_DEPTH];

  logic       s1_valid;
  logic       s1_solid;
  logic       s1_last;
  logic [2:0] s1_fg;
  logic [2:0] s1_bg;
  logic [5:0] rd_data;

  logic       out_load;
  logic       s1_free;
  logic [2:0] pix_next [6];

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign s1_free  = !s1_valid || out_load;
  assign pop      = !q_stat.empty && s1_free;

  // Single-port glyph store: one write or one read per popped request.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.is_write) begin
        glyph_store[head.addr] <= head.wdata;
      end else begin
        rd_data <= glyph_store[head.addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head.is_write) begin
      s1_solid <= head.solid;
      s1_last  <= head.last;
      s1_fg    <= head.fg;
      s1_bg    <= head.bg;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pix_next[i] = (!s1_solid && rd_data[5-i]) ? s1_fg : s1_bg;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_0      <= pix_next[0];
      pixel_1      <= pix_next[1];
      pixel_2      <= pix_next[2];
      pixel_3      <= pix_next[3];
      pixel_4      <= pix_next[4];
      pixel_5      <= pix_next[5];
      last_in_line <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= pop && !head.is_write;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/serial_attribute_text_renderer_unit.sv =====
// Serial-attribute text scanline renderer.
// Input channel (in_valid/in_ready) takes one request per cycle while the
// queue has room: a glyph row write, a line start, or a screen cell byte. Only
// a cell byte produces a result on the output channel (out_valid/out_ready):
// six 3-bit pixel colours and a flag on the last cell of the scanline.
// A cell result passes from the queue through the glyph store read register
// to the output register. Throughput is one request per cycle when the
// output is not stalled; it is set by the single-port glyph store, which
// serves one write or one read each cycle from the queue head.
// Attributes are applied in the front stage as requests arrive, and a
// four-entry queue separates it from the glyph store and output register.
// When the receiver stalls, the output register holds its result, the back
// stage stops popping, and in_ready falls once the queue is full.
// Reset clears the colours and attributes to ink 7, paper 0, no text
// attributes, and empties the pipeline. The glyph store is not cleared: every
// glyph row must be written before a cell that uses it is drawn.
module serial_attribute_text_renderer_unit
  import satr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic [10:0] glyph_index,
  input  logic [7:0]  line_number,
  input  logic        blink_phase,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  pixel_0,
  output logic [2:0]  pixel_1,
  output logic [2:0]  pixel_2,
  output logic [2:0]  pixel_3,
  output logic [2:0]  pixel_4,
  output logic [2:0]  pixel_5,
  output logic        last_in_line
);

  logic         push;
  logic         pop;
  satr_entry_t  push_entry;
  satr_entry_t  head;
  satr_q_stat_t q_stat;

  satr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .data_byte   (data_byte),
    .glyph_index (glyph_index),
    .line_number (line_number),
    .blink_phase (blink_phase),
    .q_stat      (q_stat),
    .push        (push),
    .push_entry  (push_entry)
  );

  satr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  satr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_0      (pixel_0),
    .pixel_1      (pixel_1),
    .pixel_2      (pixel_2),
    .pixel_3      (pixel_3),
    .pixel_4      (pixel_4),
    .pixel_5      (pixel_5),
    .last_in_line (last_in_line)
  );

`ifndef SYNTHESIS
  a_reset_no_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result presented straight after reset");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (q_stat.count < Q_CW'(Q_DEPTH)))
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty request queue");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> q_stat.empty)
    else $error("request queue not empty after reset");
`endif

endmodule
